// ===== rtl/sct_pkg.sv =====
`timescale 1ns / 1ps

package sct_pkg;

    // Series length and output format.
    localparam int NUM_TERMS        = 9;
    localparam int RESULT_FRAC_BITS = 30;

    // Port field widths.
    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;

    // Range reduction: the Q16 angle is moved to Q44, so it is shifted by 28 bits.
    localparam int ANG_SCALE   = 28;
    localparam int TURN_W      = 48;
    localparam int U_W         = 61;
    localparam int TQ_W        = 14;
    localparam int RED_RECIP_W = 22;
    localparam int RED_SHIFT   = 40;
    localparam int RED_FRAC    = 44;

    // Series datapath.
    localparam int SERIES_FRAC = 30;
    localparam int SQ_FRAC     = 26;
    localparam int ANG_W       = 33;
    localparam int SQ_W        = 30;
    localparam int TERM_W      = 37;
    localparam int ACC_W       = 37;
    localparam int PRD_W       = 37;
    localparam int MAG_W       = 36;
    localparam int HALF_W      = 18;
    localparam int QUO_W       = 35;
    localparam int RCP_W       = 36;
    localparam int RCP_SHIFT   = 36;
    localparam int DIV_W       = 10;
    localparam int REM_W       = 12;
    localparam int OUT_SHIFT   = SERIES_FRAC - RESULT_FRAC_BITS;

    // Pi in Q44 (truncated), its double and its triple.
    localparam logic [TURN_W-1:0] HALF_TURN        = 48'h3243F6A8885A;
    localparam logic [TURN_W-1:0] FULL_TURN        = 48'h6487ED5110B4;
    localparam logic [TURN_W-1:0] THREE_HALF_TURNS = 48'h96CBE3F9990E;

    // 8192 whole turns: enough to make every shifted angle positive.
    localparam logic [U_W-1:0] TURN_OFFSET = {FULL_TURN, 13'b0};

    // floor(2^68 / FULL_TURN): never above the true reciprocal.
    localparam logic [RED_RECIP_W-1:0] RED_RECIP = 22'd2670176;

    // 1.0 in the series format.
    localparam logic signed [TERM_W-1:0] ONE_TERM =
        {{(TERM_W-SERIES_FRAC-1){1'b0}}, 1'b1, {SERIES_FRAC{1'b0}}};

    // Saturation limits of the scaled sum.
    localparam logic signed [ACC_W-1:0] SAT_POS =
        {{(ACC_W-1){1'b0}}, 1'b1} << RESULT_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SAT_NEG = -SAT_POS;

    // Control that travels alongside each word.
    typedef struct packed {
        logic valid;
        logic want_cos;
    } t_ctl;

    // Running state of the series for one word.
    typedef struct packed {
        logic signed [TERM_W-1:0] term;
        logic signed [ACC_W-1:0]  acc;
        logic [SQ_W-1:0]          sq;
    } t_series;

    // Divisors of one series step and their reciprocals.
    typedef struct packed {
        logic [DIV_W-1:0] div_sin;
        logic [DIV_W-1:0] div_cos;
        logic [RCP_W-1:0] rcp_sin;
        logic [RCP_W-1:0] rcp_cos;
    } t_divs;

    // Product of the two factorial factors that step idx divides by.
    function automatic logic [DIV_W-1:0] divisor(input logic want_cos, input int idx);
        int lo;
        lo = want_cos ? (2 * idx - 1) : (2 * idx);
        return DIV_W'(lo * (lo + 1));
    endfunction

endpackage

// ===== rtl/sct_reduce.sv =====
`timescale 1ns / 1ps

module sct_reduce (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_req_type,
    input  logic signed [sct_pkg::ANGLE_W-1:0] i_angle,
    output sct_pkg::t_ctl                       o_ctl,
    output sct_pkg::t_series                    o_ser
);

    sct_pkg::t_ctl r_ctl [1:6];

    logic [sct_pkg::U_W:0]                           a44;
    logic [sct_pkg::U_W:0]                           n_u;
    logic [sct_pkg::U_W-sct_pkg::ANG_SCALE+sct_pkg::RED_RECIP_W-1:0] red_prod;
    logic [sct_pkg::TQ_W+sct_pkg::TURN_W-1:0]        qft_prod;
    logic                                            big;
    logic [sct_pkg::TURN_W:0]                        v;
    logic signed [2*sct_pkg::ANG_W-1:0]              sq_prod;

    logic [sct_pkg::U_W-1:0]          r_u1;
    logic [sct_pkg::TURN_W-1:0]       r_ulow2;
    logic [sct_pkg::TQ_W-1:0]         r_qe2;
    logic [sct_pkg::TURN_W-1:0]       r_ulow3;
    logic [sct_pkg::TURN_W-1:0]       r_qft3;
    logic [sct_pkg::TURN_W-1:0]       r_rem4;
    logic signed [sct_pkg::ANG_W-1:0] r_ang5;
    sct_pkg::t_series                 r_ser6;

    // Valid bits and the selector move one stage per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 6; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (i_en) begin
            r_ctl[1].valid    <= i_valid;
            r_ctl[1].want_cos <= i_req_type;
            for (int s = 2; s <= 6; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // Stage 1: angle to Q44, plus half a turn, plus whole turns to make it positive.
    assign a44 = {{(sct_pkg::U_W+1-sct_pkg::ANGLE_W-sct_pkg::ANG_SCALE){i_angle[
                    sct_pkg::ANGLE_W-1]}}, i_angle, {sct_pkg::ANG_SCALE{1'b0}}};
    assign n_u = a44 + {{(sct_pkg::U_W+1-sct_pkg::TURN_W){1'b0}}, sct_pkg::HALF_TURN}
                     + {1'b0, sct_pkg::TURN_OFFSET};

    // Stage 2: estimate of the turn count, low by at most one.
    assign red_prod = {{sct_pkg::RED_RECIP_W{1'b0}}, r_u1[sct_pkg::U_W-1:sct_pkg::ANG_SCALE]}
                    * {{(sct_pkg::U_W-sct_pkg::ANG_SCALE){1'b0}}, sct_pkg::RED_RECIP};

    // Stage 3: whole turns to take away. Only the low bits matter from here on.
    assign qft_prod = {{sct_pkg::TURN_W{1'b0}}, r_qe2}
                    * {{sct_pkg::TQ_W{1'b0}}, sct_pkg::FULL_TURN};

    // Stage 5: fold the remainder into one turn, remove the half turn and drop to Q30.
    assign big = (r_rem4 >= sct_pkg::FULL_TURN);
    assign v   = {1'b0, r_rem4}
               - {1'b0, big ? sct_pkg::THREE_HALF_TURNS : sct_pkg::HALF_TURN};

    // Stage 6: the square of the reduced angle and the first term.
    assign sq_prod = r_ang5 * r_ang5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1    <= n_u[sct_pkg::U_W-1:0];
            r_qe2   <= red_prod[sct_pkg::RED_SHIFT+sct_pkg::TQ_W-1:sct_pkg::RED_SHIFT];
            r_ulow2 <= r_u1[sct_pkg::TURN_W-1:0];
            r_qft3  <= qft_prod[sct_pkg::TURN_W-1:0];
            r_ulow3 <= r_ulow2;
            r_rem4  <= r_ulow3 - r_qft3;
            r_ang5  <= v[sct_pkg::RED_FRAC-sct_pkg::SERIES_FRAC+sct_pkg::ANG_W-1:
                         sct_pkg::RED_FRAC-sct_pkg::SERIES_FRAC];
            r_ser6.sq   <= sq_prod[2*sct_pkg::SERIES_FRAC-sct_pkg::SQ_FRAC+sct_pkg::SQ_W-1:
                                   2*sct_pkg::SERIES_FRAC-sct_pkg::SQ_FRAC];
            r_ser6.term <= r_ctl[5].want_cos ? sct_pkg::ONE_TERM
                         : {{(sct_pkg::TERM_W-sct_pkg::ANG_W){r_ang5[sct_pkg::ANG_W-1]}},
                            r_ang5};
            r_ser6.acc  <= '0;
        end
    end

    assign o_ctl = r_ctl[6];
    assign o_ser = r_ser6;

endmodule

// ===== rtl/sct_term.sv =====
`timescale 1ns / 1ps

module sct_term (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  sct_pkg::t_divs   i_divs,
    input  sct_pkg::t_ctl    i_ctl,
    input  sct_pkg::t_series i_ser,
    output sct_pkg::t_ctl    o_ctl,
    output sct_pkg::t_series o_ser
);

    sct_pkg::t_ctl r_ctl [1:5];
    logic signed [sct_pkg::ACC_W-1:0] r_acc [1:5];
    logic [sct_pkg::SQ_W-1:0]         r_sq  [1:5];

    logic signed [sct_pkg::TERM_W+sct_pkg::SQ_W:0] t_prod;
    logic signed [sct_pkg::PRD_W-1:0]              mag_full;
    logic [sct_pkg::RCP_W-1:0]                     rcp;
    logic [sct_pkg::HALF_W+sct_pkg::RCP_W-1:0]     phi;
    logic [sct_pkg::HALF_W+sct_pkg::RCP_W-1:0]     plo;
    logic [sct_pkg::HALF_W+sct_pkg::RCP_W:0]       qsum;
    logic [sct_pkg::DIV_W-1:0]                     dsel;
    logic [sct_pkg::REM_W-1:0]                     qd;
    logic [sct_pkg::REM_W-1:0]                     rem;
    logic                                          carry;
    logic [sct_pkg::TERM_W-1:0]                    qx;
    logic [sct_pkg::TERM_W-1:0]                    n_term;

    logic signed [sct_pkg::PRD_W-1:0]       r_prod1;
    logic                                   r_neg2;
    logic [sct_pkg::MAG_W-1:0]              r_mag2;
    logic                                   r_neg3;
    logic [sct_pkg::HALF_W+sct_pkg::RCP_W-1:0] r_phi3;
    logic [sct_pkg::RCP_W-1:0]              r_plo3;
    logic [sct_pkg::REM_W-1:0]              r_mlow3;
    logic                                   r_neg4;
    logic [sct_pkg::QUO_W-1:0]              r_q4;
    logic [sct_pkg::REM_W-1:0]              r_mlow4;
    logic signed [sct_pkg::TERM_W-1:0]      r_term5;

    // Valid bits and the selector follow the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 5; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (i_en) begin
            r_ctl[1] <= i_ctl;
            for (int s = 2; s <= 5; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // Stage 1: previous term times the square, back to Q30 with a floor shift.
    assign t_prod = $signed(i_ser.term) * $signed({1'b0, i_ser.sq});

    // Stage 2: magnitude and sign of that product.
    assign mag_full = r_prod1[sct_pkg::PRD_W-1] ? -r_prod1 : r_prod1;

    // Stage 3: magnitude times the reciprocal of the divisor, in two halves.
    assign rcp = r_ctl[2].want_cos ? i_divs.rcp_cos : i_divs.rcp_sin;
    assign phi = {{sct_pkg::RCP_W{1'b0}}, r_mag2[sct_pkg::MAG_W-1:sct_pkg::HALF_W]}
               * {{sct_pkg::HALF_W{1'b0}}, rcp};
    assign plo = {{sct_pkg::RCP_W{1'b0}}, r_mag2[sct_pkg::HALF_W-1:0]}
               * {{sct_pkg::HALF_W{1'b0}}, rcp};

    // Stage 4: join the halves. The quotient estimate is exact or one short.
    assign qsum = {1'b0, r_phi3} + {{(sct_pkg::HALF_W+1){1'b0}}, r_plo3};

    // Stage 5: the low bits of the remainder decide the last unit, then the sign flips.
    assign dsel  = r_ctl[4].want_cos ? i_divs.div_cos : i_divs.div_sin;
    assign qd    = r_q4[sct_pkg::REM_W-1:0]
                 * {{(sct_pkg::REM_W-sct_pkg::DIV_W){1'b0}}, dsel};
    assign rem   = r_mlow4 - qd;
    assign carry = (rem >= {{(sct_pkg::REM_W-sct_pkg::DIV_W){1'b0}}, dsel});
    assign qx    = {{(sct_pkg::TERM_W-sct_pkg::QUO_W){1'b0}}, r_q4};
    assign n_term = (r_neg4 ? qx : ~qx)
                  + {{(sct_pkg::TERM_W-1){1'b0}}, r_neg4 ? carry : !carry};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1 <= t_prod[sct_pkg::SQ_FRAC+sct_pkg::PRD_W-1:sct_pkg::SQ_FRAC];
            r_acc[1] <= i_ser.acc + i_ser.term;
            r_sq[1]  <= i_ser.sq;
            for (int s = 2; s <= 5; s++) begin
                r_acc[s] <= r_acc[s-1];
                r_sq[s]  <= r_sq[s-1];
            end
            r_neg2  <= r_prod1[sct_pkg::PRD_W-1];
            r_mag2  <= mag_full[sct_pkg::MAG_W-1:0];
            r_neg3  <= r_neg2;
            r_phi3  <= phi;
            r_plo3  <= plo[sct_pkg::HALF_W+sct_pkg::RCP_W-1:sct_pkg::HALF_W];
            r_mlow3 <= r_mag2[sct_pkg::REM_W-1:0];
            r_neg4  <= r_neg3;
            r_q4    <= qsum[sct_pkg::HALF_W+sct_pkg::QUO_W-1:sct_pkg::HALF_W];
            r_mlow4 <= r_mlow3;
            r_term5 <= n_term;
        end
    end

    assign o_ctl      = r_ctl[5];
    assign o_ser.term = r_term5;
    assign o_ser.acc  = r_acc[5];
    assign o_ser.sq   = r_sq[5];

endmodule

// ===== rtl/sct_out.sv =====
`timescale 1ns / 1ps

module sct_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sct_pkg::t_ctl                       i_ctl,
    input  logic signed [sct_pkg::TERM_W-1:0]   i_term,
    input  logic signed [sct_pkg::ACC_W-1:0]    i_acc,
    input  logic                                i_ready,
    output logic                                o_en,
    output logic                                o_valid,
    output logic signed [sct_pkg::VALUE_W-1:0]  o_value
);

    logic                               r_sum_v;
    logic signed [sct_pkg::ACC_W-1:0]   r_sum;
    logic [1:0]                         r_cnt;
    logic [1:0]                         n_cnt;
    logic signed [sct_pkg::VALUE_W-1:0] r_head;
    logic signed [sct_pkg::VALUE_W-1:0] r_tail;

    logic                               en;
    logic                               push;
    logic                               pop;
    logic signed [sct_pkg::ACC_W-1:0]   scaled;
    logic signed [sct_pkg::ACC_W-1:0]   sat;

    // The pipeline moves while the output buffer has a free slot.
    assign en   = (r_cnt != 2'd2);
    assign push = en && r_sum_v;
    assign pop  = o_valid && i_ready;

    // Scale to the output format and saturate to plus or minus one.
    assign scaled = r_sum >>> sct_pkg::OUT_SHIFT;

    always_comb begin
        priority if (scaled > sct_pkg::SAT_POS) begin
            sat = sct_pkg::SAT_POS;
        end else if (scaled < sct_pkg::SAT_NEG) begin
            sat = sct_pkg::SAT_NEG;
        end else begin
            sat = scaled;
        end
    end

    // Occupancy of the two-word output buffer.
    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_v <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (en) begin
                r_sum_v <= i_ctl.valid;
            end
            r_cnt <= n_cnt;
        end
    end

    // Final add of the last term, then the buffer words.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= i_acc + i_term;
        end
        unique case ({push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_head <= sat[sct_pkg::VALUE_W-1:0];
                end else begin
                    r_tail <= sat[sct_pkg::VALUE_W-1:0];
                end
            end
            2'b01: begin
                r_head <= r_tail;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_head <= sat[sct_pkg::VALUE_W-1:0];
                end else begin
                    r_head <= r_tail;
                    r_tail <= sat[sct_pkg::VALUE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_en    = en;
    assign o_valid = (r_cnt != 2'd0);
    assign o_value = r_head;

endmodule

// ===== rtl/sine_cosine_taylor.sv =====
// Sine or cosine of a Q16.16 angle in radians, chosen per word by i_req_type (0 sine,
// 1 cosine), returned as Q2.30 saturated to plus or minus one. The angle is first folded
// into [-pi, pi) and then summed as a nine-term Taylor series. The unit is fully pipelined
// and takes one word every cycle while the output buffer is not full; a result passes
// through six stages of range reduction and square, five per series step (multiply by
// the square, magnitude, reciprocal multiply in two halves, partial sum, remainder fix
// and sign), one for the final add and one in the output buffer.
// That two-word buffer lets new words enter while a result waits; once it is full, every
// stage holds until a result is taken.
`timescale 1ns / 1ps

module sine_cosine_taylor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_req_type,
    input  logic signed [sct_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [sct_pkg::VALUE_W-1:0]  o_value
);

    logic             en;
    sct_pkg::t_ctl    ctl_chain [0:sct_pkg::NUM_TERMS-1];
    sct_pkg::t_series ser_chain [0:sct_pkg::NUM_TERMS-1];

    // Range reduction, square and first term.
    sct_reduce u_reduce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_angle    (i_angle),
        .o_ctl      (ctl_chain[0]),
        .o_ser      (ser_chain[0])
    );

    // One pipelined step for each further term of the series.
    for (genvar k = 1; k < sct_pkg::NUM_TERMS; k++) begin : g_term
        localparam logic [sct_pkg::DIV_W-1:0] DIV_SIN = sct_pkg::divisor(1'b0, k);
        localparam logic [sct_pkg::DIV_W-1:0] DIV_COS = sct_pkg::divisor(1'b1, k);
        localparam logic [63:0] RCP_SIN_FULL = (64'd1 << sct_pkg::RCP_SHIFT) / DIV_SIN;
        localparam logic [63:0] RCP_COS_FULL = (64'd1 << sct_pkg::RCP_SHIFT) / DIV_COS;

        sct_pkg::t_divs divs;

        assign divs.div_sin = DIV_SIN;
        assign divs.div_cos = DIV_COS;
        assign divs.rcp_sin = RCP_SIN_FULL[sct_pkg::RCP_W-1:0];
        assign divs.rcp_cos = RCP_COS_FULL[sct_pkg::RCP_W-1:0];

        sct_term u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_divs  (divs),
            .i_ctl   (ctl_chain[k-1]),
            .i_ser   (ser_chain[k-1]),
            .o_ctl   (ctl_chain[k]),
            .o_ser   (ser_chain[k])
        );
    end

    // Final sum, saturation and output buffer.
    sct_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_chain[sct_pkg::NUM_TERMS-1]),
        .i_term  (ser_chain[sct_pkg::NUM_TERMS-1].term),
        .i_acc   (ser_chain[sct_pkg::NUM_TERMS-1].acc),
        .i_ready (i_ready),
        .o_en    (en),
        .o_valid (o_valid),
        .o_value (o_value)
    );

    assign o_ready = en;

endmodule

// ===== sim/sine_cosine_taylor_tb.sv =====
`timescale 1ns / 1ps

module sine_cosine_taylor_tb;

    // Selector codes carried by i_req_type.
    localparam logic SEL_SINE   = 1'b0;
    localparam logic SEL_COSINE = 1'b1;

    // Pi in Q44 (truncated) and the full turn, for the angle fold.
    localparam longint PI_Q44     = 64'sh3243F6A8885A;
    localparam longint TWO_PI_Q44 = 2 * PI_Q44;
    localparam longint ONE_Q30    = 64'sd1 <<< 30;

    // Angles in Q16.16 used in the directed part.
    localparam int PI_Q16      = 205887;
    localparam int HALF_PI_Q16 = 102944;
    localparam int FOUR_Q16    = 262144;

    localparam int RANDOM_WORDS = 1850;
    localparam int IDLE_PCT     = 37;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 5 * (sct_pkg::NUM_TERMS - 1) + 8 + 16;
    localparam int FULL_SCALE   = 1 << sct_pkg::RESULT_FRAC_BITS;

    typedef struct packed {
        logic                               req_type;
        logic signed [sct_pkg::ANGLE_W-1:0] angle;
    } t_word;

    logic                               i_clk      = 1'b0;
    logic                               i_rst_n    = 1'b0;
    logic                               i_valid    = 1'b0;
    logic                               i_req_type = SEL_SINE;
    logic signed [sct_pkg::ANGLE_W-1:0] i_angle    = '0;
    logic                               i_ready    = 1'b0;
    logic                               o_ready;
    logic                               o_valid;
    logic signed [sct_pkg::VALUE_W-1:0] o_value;

    t_word                              pending_words[$];
    logic signed [sct_pkg::VALUE_W-1:0] expected_values[$];
    t_word                              next_word;
    logic signed [sct_pkg::VALUE_W-1:0] want_value;
    logic                               calm = 1'b0;

    int words_sent   = 0;
    int sine_words   = 0;
    int cosine_words = 0;
    int checked      = 0;
    int full_scale   = 0;
    int errors       = 0;
    int idle_cycles  = 0;

    sine_cosine_taylor u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_angle    (i_angle),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value    (o_value)
    );

    // Free-running clock, 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Fold the angle into [-pi, pi), run the series and clamp the sum to
    // plus or minus one.
    function automatic logic signed [sct_pkg::VALUE_W-1:0] taylor_value(
        input logic req_type, input logic signed [sct_pkg::ANGLE_W-1:0] angle);
        longint          folded;
        longint          red;
        longint unsigned mag;
        longint          sq;
        longint          term;
        longint          acc;
        longint          lo;
        longint          prod;
        longint          res;
        longint          lim;
        folded = (longint'(angle) * (64'sd1 <<< 28) + PI_Q44) % TWO_PI_Q44;
        if (folded < 0)
            folded += TWO_PI_Q44;
        red  = (folded - PI_Q44) >>> 14;
        mag  = (red < 0) ? -red : red;
        sq   = longint'((mag * mag) >> 34);
        term = (req_type == SEL_COSINE) ? ONE_Q30 : red;
        acc  = term;
        for (int k = 1; k < sct_pkg::NUM_TERMS; k++) begin
            lo   = (req_type == SEL_COSINE) ? 2 * k - 1 : 2 * k;
            prod = (term * sq) >>> 26;
            term = -(prod / (lo * (lo + 1)));
            acc += term;
        end
        res = acc >>> (30 - sct_pkg::RESULT_FRAC_BITS);
        lim = 64'sd1 <<< sct_pkg::RESULT_FRAC_BITS;
        if (res > lim)
            res = lim;
        if (res < -lim)
            res = -lim;
        return res[sct_pkg::VALUE_W-1:0];
    endfunction

    // Input driver: records the expected result of each accepted word and
    // presents the next pending one unless this cycle is idled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_values.push_back(taylor_value(i_req_type, i_angle));
                words_sent++;
                if (i_req_type == SEL_COSINE)
                    cosine_words++;
                else
                    sine_words++;
            end
            if (!i_valid || o_ready) begin
                if (pending_words.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_word = pending_words.pop_front();
                    i_valid    <= 1'b1;
                    i_req_type <= next_word.req_type;
                    i_angle    <= next_word.angle;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            // A stretch in the middle of the run goes without any idling.
            calm <= (words_sent >= 700 && words_sent < 1000);
        end
    end

    // Output monitor: checks each result against the oldest expectation and
    // stalls the output at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                checked++;
                if (o_value == FULL_SCALE || o_value == -FULL_SCALE)
                    full_scale++;
                if (expected_values.size() == 0) begin
                    $error("value: no word outstanding, got %0d", o_value);
                    errors++;
                end else begin
                    want_value = expected_values.pop_front();
                    if (o_value !== want_value) begin
                        $error("value: expected %0d, got %0d", want_value, o_value);
                        errors++;
                    end
                end
            end
            i_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("sine_cosine_taylor_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic signed [sct_pkg::ANGLE_W-1:0] corners[12];
        t_word                              w;
        int                                 shape;
        int                                 k;
        corners = '{0, 1, -1, 32'sh7FFFFFFF, 32'sh80000000, PI_Q16, -PI_Q16,
                    PI_Q16 + 1, HALF_PI_Q16, -HALF_PI_Q16, 2 * PI_Q16 + 1, 32'sh00010000};

        // Directed part: range limits, both ends of the fold, quarter turns
        // and the full-scale points, each with both selectors.
        foreach (corners[i]) begin
            pending_words.push_back('{SEL_SINE, corners[i]});
            pending_words.push_back('{SEL_COSINE, corners[i]});
        end

        // Random part: raw 32-bit angles, angles within a few radians, and
        // angles close to multiples of pi and of pi/2.
        repeat (RANDOM_WORDS) begin
            w.req_type = 1'($urandom_range(0, 1));
            shape      = $urandom_range(0, 99);
            if (shape < 35) begin
                w.angle = $urandom;
            end else if (shape < 70) begin
                w.angle = int'($urandom_range(0, 2 * FOUR_Q16)) - FOUR_Q16;
            end else if (shape < 90) begin
                k       = int'($urandom_range(0, 40)) - 20;
                w.angle = k * PI_Q16 + int'($urandom_range(0, 128)) - 64;
            end else begin
                k       = int'($urandom_range(0, 40)) - 20;
                w.angle = k * HALF_PI_Q16 + int'($urandom_range(0, 8)) - 4;
            end
            pending_words.push_back(w);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (pending_words.size() > 0 || i_valid || expected_values.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (expected_values.size() > 0) begin
            $error("value: %0d results never arrived", expected_values.size());
            errors++;
        end

        $display("Run covered %0d sine and %0d cosine words, %0d results checked.",
                 sine_words, cosine_words, checked);
        $display("Of those, %0d results sat at full scale; %0d mismatches.",
                 full_scale, errors);
        if (errors == 0) begin
            $display("sine_cosine_taylor_tb passed");
        end else begin
            $display("sine_cosine_taylor_tb failed");
        end
        $finish;
    end

endmodule
